### rtl/wait_for_graph_deadlock_detector_defines.svh
// Assertion macros used by the checker file.
`ifndef WAIT_FOR_GRAPH_DEADLOCK_DETECTOR_DEFINES_SVH
`define WAIT_FOR_GRAPH_DEADLOCK_DETECTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define WFGD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wfgd check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define WFGD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wfgd check failed");

`endif

### rtl/wfgd_pkg.sv
// Shared constants and types of the wait-for graph deadlock detector.
`timescale 1ns / 1ps
package wfgd_pkg;

  localparam int MAX_THREADS = 32;
  localparam int MAX_LOCKS   = 32;
  localparam int ID_W        = 64;
  localparam int WAIT_W      = 6;
  localparam int TIDX_W      = $clog2(MAX_THREADS);
  localparam int TCNT_W      = $clog2(MAX_THREADS + 1);
  localparam int LIDX_W      = $clog2(MAX_LOCKS);
  localparam int LCNT_W      = $clog2(MAX_LOCKS + 1);
  localparam int SCAN_W      = (LCNT_W > TCNT_W) ? LCNT_W : TCNT_W;
  localparam logic [WAIT_W-1:0] WAITER_MAX = '1;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_ACQUIRE = 2'd1,
    CMD_UNLOCK  = 2'd2,
    CMD_CHECK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_LOCK_FULL   = 2'd1,
    STS_THREAD_FULL = 2'd2,
    STS_NOT_FOUND   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LSCAN,
    S_VSCAN,
    S_ADD_A,
    S_ADD_B,
    S_ROW_RD,
    S_ROW_MOD,
    S_RESULT,
    S_DROOT,
    S_DREAD,
    S_DEVAL,
    S_DFIND,
    S_EMIT_RD,
    S_EMIT_WR
  } fsm_t;

  typedef struct packed {
    logic [ID_W-1:0]   addr;
    logic [ID_W-1:0]   owner;
    logic [WAIT_W-1:0] waiters;
  } lock_entry_t;

endpackage

### rtl/wfgd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wfgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/wait_for_graph_deadlock_detector.sv
// Top level: lock table, wait-for graph and cycle search sequencer.
`timescale 1ns / 1ps
// Wait-for graph deadlock detector.
// Input channel (in_valid/in_ready) carries one lock event per beat: cmd,
// thread_ident, lock_address. Output channel (out_valid/out_ready) carries
// results: status, deadlock_found, cycle_thread, last_of_run. Every event
// gives one result beat; a check that hits a cycle gives one beat per thread
// on the cycle plus a closing beat that repeats the first thread.
// One event is worked at a time. Request/acquire/unlock: a sweep of the lock
// RAM, then for a request/acquire that finds its lock a sweep of the vertex
// RAM and, if the edge's vertices exist or fit, a row read-modify-write of the
// matrix RAM. A check walks the matrix RAM by edge probes and pops, then
// emits its beats; its length grows with the number of vertices and edges.
// in_ready is high only while the sequencer is idle; a finished result sits
// in the output register, so the next event can be taken while it waits.
// A stalled receiver holds the sequencer only when a new result must be
// loaded into a still-full output register.
// Reset (rst, synchronous) empties the lock table, the graph and the output
// register at once; no clearing pass is needed.
module wait_for_graph_deadlock_detector (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 cmd,
  input  logic [wfgd_pkg::ID_W-1:0]  thread_ident,
  input  logic [wfgd_pkg::ID_W-1:0]  lock_address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic                       deadlock_found,
  output logic [wfgd_pkg::ID_W-1:0]  cycle_thread,
  output logic                       last_of_run
);
  import wfgd_pkg::*;

  fsm_t state, state_next;

  // latched event
  cmd_t            cmd_q;
  logic [ID_W-1:0] thr_q, addr_q;

  // sweep control
  logic [SCAN_W-1:0] scan_cnt;
  logic              rd_pend;
  logic [SCAN_W-1:0] rd_idx;

  // lock hit
  logic              s_f;
  logic [LIDX_W-1:0] s_idx;
  lock_entry_t       s_ent;

  // vertex hits
  logic              va_f, vb_f;
  logic [TIDX_W-1:0] va, vb;

  logic [TCNT_W-1:0]      vcount;
  logic [MAX_LOCKS-1:0]   lock_valid;
  logic [MAX_THREADS-1:0] row_valid;
  status_t                res_status;

  // search state
  logic [TCNT_W-1:0]      root, sp, p;
  logic [MAX_THREADS-1:0] onstack, done;
  logic [TIDX_W-1:0]      stk_node [MAX_THREADS];
  logic [TCNT_W-1:0]      stk_next [MAX_THREADS];
  logic [TIDX_W-1:0]      hit_j;

  // output register
  logic            o_valid, o_dl, o_last;
  status_t         o_status;
  logic [ID_W-1:0] o_thr;

  // RAM ports
  logic              v_we, v_re;
  logic [TIDX_W-1:0] v_waddr, v_raddr;
  logic [ID_W-1:0]   v_wdata, v_rdata;
  logic              m_we, m_re;
  logic [TIDX_W-1:0] m_waddr, m_raddr;
  logic [MAX_THREADS-1:0] m_wdata, m_rdata;
  logic [TIDX_W-1:0] m_raddr_q;
  logic              l_we, l_re;
  logic [LIDX_W-1:0] l_waddr, l_raddr;
  lock_entry_t       l_wdata, l_rdata;

  wfgd_ram #(.WIDTH(ID_W), .DEPTH(MAX_THREADS)) u_vertex_ram (
    .clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .re(v_re), .raddr(v_raddr), .rdata(v_rdata)
  );
  wfgd_ram #(.WIDTH(MAX_THREADS), .DEPTH(MAX_THREADS)) u_matrix_ram (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .re(m_re), .raddr(m_raddr), .rdata(m_rdata)
  );
  wfgd_ram #(.WIDTH($bits(lock_entry_t)), .DEPTH(MAX_LOCKS)) u_lock_ram (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
  );

  // derived values
  logic              out_free, in_acc;
  logic              scan_issue, lscan_done, vscan_done;
  logic              free_any;
  logic [LIDX_W-1:0] free_idx;
  logic [1:0]        need;
  logic              thr_full;
  logic [MAX_THREADS-1:0] row, cand, bitb;
  logic [TCNT_W-1:0] sp_m1;
  logic [TIDX_W-1:0] stk_idx, top, j_idx;
  logic [TCNT_W-1:0] top_next;
  logic              j_f;
  lock_entry_t       new_ent, acq_ent, req_ent;

  assign out_free  = !o_valid || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign sp_m1     = sp - TCNT_W'(1);
  assign stk_idx   = (state == S_DFIND || state == S_EMIT_RD) ?
                     p[TIDX_W-1:0] : sp_m1[TIDX_W-1:0];
  assign top       = stk_node[stk_idx];
  assign top_next  = stk_next[stk_idx];

  always_comb begin
    scan_issue = 1'b0;
    if (state == S_LSCAN) begin
      scan_issue = scan_cnt < SCAN_W'(MAX_LOCKS);
    end else if (state == S_VSCAN) begin
      scan_issue = scan_cnt < SCAN_W'(vcount);
    end
  end
  assign lscan_done = (state == S_LSCAN) && !scan_issue && !rd_pend;
  assign vscan_done = (state == S_VSCAN) && !scan_issue && !rd_pend;

  // lowest free lock slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = MAX_LOCKS - 1; i >= 0; i--) begin
      if (!lock_valid[i]) begin
        free_any = 1'b1;
        free_idx = LIDX_W'(i);
      end
    end
  end

  always_comb begin
    need = {1'b0, !va_f} + {1'b0, (s_ent.owner != thr_q) && !vb_f};
    thr_full = ({1'b0, vcount} + (TCNT_W + 1)'(need)) > (TCNT_W + 1)'(MAX_THREADS);
  end

  // matrix row as read; rows never written read as empty
  assign row  = m_rdata & {MAX_THREADS{row_valid[m_raddr_q]}};
  assign bitb = MAX_THREADS'(1) << vb;

  always_ff @(posedge clk) begin
    if (m_re) begin
      m_raddr_q <= m_raddr;
    end
  end

  // next edge of the stack top: first set bit at or above its cursor
  always_comb begin
    j_f   = 1'b0;
    j_idx = '0;
    for (int k = 0; k < MAX_THREADS; k++) begin
      cand[k] = row[k] && (TCNT_W'(k) >= top_next) && (TCNT_W'(k) < vcount);
    end
    for (int k = MAX_THREADS - 1; k >= 0; k--) begin
      if (cand[k]) begin
        j_f   = 1'b1;
        j_idx = TIDX_W'(k);
      end
    end
  end

  always_comb begin
    new_ent = '{addr: addr_q, owner: thr_q, waiters: '0};
    acq_ent = '{addr: s_ent.addr, owner: thr_q,
                waiters: (s_ent.waiters != '0) ? s_ent.waiters - WAIT_W'(1) : '0};
    req_ent = '{addr: s_ent.addr, owner: s_ent.owner,
                waiters: s_ent.waiters + WAIT_W'(1)};
  end

  // next state and RAM control
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    v_we = 1'b0; v_waddr = vcount[TIDX_W-1:0]; v_wdata = thr_q;
    v_re = 1'b0; v_raddr = scan_cnt[TIDX_W-1:0];
    m_we = 1'b0; m_waddr = va; m_wdata = row | bitb;
    m_re = 1'b0; m_raddr = va;
    l_we = 1'b0; l_waddr = s_idx; l_wdata = acq_ent;
    l_re = 1'b0; l_raddr = scan_cnt[LIDX_W-1:0];
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (cmd_t'(cmd) == CMD_CHECK) ? S_DROOT : S_LSCAN;
        end
      end
      S_LSCAN: begin
        l_re = scan_issue;
        if (lscan_done) begin
          case (cmd_q)
            CMD_REQUEST: state_next = s_f ? S_VSCAN : S_RESULT;
            CMD_ACQUIRE: begin
              if (s_f) begin
                state_next = S_VSCAN;
              end else begin
                state_next = S_RESULT;
                l_we    = free_any;
                l_waddr = free_idx;
                l_wdata = new_ent;
              end
            end
            default: state_next = S_RESULT;
          endcase
        end
      end
      S_VSCAN: begin
        v_re = scan_issue;
        if (vscan_done) begin
          if (cmd_q == CMD_ACQUIRE) begin
            l_we = 1'b1;
            state_next = (va_f && vb_f) ? S_ROW_RD : S_RESULT;
          end else begin
            state_next = thr_full ? S_RESULT : S_ADD_A;
          end
        end
      end
      S_ADD_A: begin
        v_we = !va_f;
        state_next = S_ADD_B;
      end
      S_ADD_B: begin
        v_we    = (s_ent.owner != thr_q) && !vb_f;
        v_wdata = s_ent.owner;
        state_next = S_ROW_RD;
      end
      S_ROW_RD: begin
        m_re = 1'b1;
        state_next = S_ROW_MOD;
      end
      S_ROW_MOD: begin
        if (cmd_q == CMD_ACQUIRE) begin
          m_we    = 1'b1;
          m_wdata = row & ~bitb;
        end else if ((row & bitb) == '0) begin
          m_we    = 1'b1;
          l_we    = s_ent.waiters != WAITER_MAX;
          l_wdata = req_ent;
        end
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DROOT: begin
        if (root >= vcount) begin
          state_next = S_RESULT;
        end else if (!onstack[root[TIDX_W-1:0]] && !done[root[TIDX_W-1:0]]) begin
          state_next = S_DREAD;
        end
      end
      S_DREAD: begin
        m_re    = 1'b1;
        m_raddr = top;
        state_next = S_DEVAL;
      end
      S_DEVAL: begin
        if (!j_f) begin
          state_next = (sp == TCNT_W'(1)) ? S_DROOT : S_DREAD;
        end else if (onstack[j_idx]) begin
          state_next = S_DFIND;
        end else begin
          state_next = S_DREAD;
        end
      end
      S_DFIND: begin
        if (top == hit_j) begin
          state_next = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        v_re    = 1'b1;
        v_raddr = (p < sp) ? top : hit_j;
        state_next = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (out_free) begin
          state_next = (p == sp) ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state that reset clears
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount     <= '0;
      lock_valid <= '0;
      row_valid  <= '0;
      o_valid    <= 1'b0;
    end else begin
      if ((state == S_RESULT || state == S_EMIT_WR) && out_free) begin
        o_valid <= 1'b1;
      end else if (out_ready) begin
        o_valid <= 1'b0;
      end
      if (l_we && state == S_LSCAN) begin
        lock_valid[l_waddr] <= 1'b1;
      end
      if (lscan_done && cmd_q == CMD_UNLOCK && s_f && s_ent.waiters == '0) begin
        lock_valid[s_idx] <= 1'b0;
      end
      if (v_we) begin
        vcount <= vcount + TCNT_W'(1);
      end
      if (m_we) begin
        row_valid[m_waddr] <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q    <= cmd_t'(cmd);
      thr_q    <= thread_ident;
      addr_q   <= lock_address;
      scan_cnt <= '0;
      rd_pend  <= 1'b0;
      s_f      <= 1'b0;
      res_status <= STS_OK;
      root     <= '0;
      onstack  <= '0;
      done     <= '0;
    end

    if (state == S_LSCAN || state == S_VSCAN) begin
      rd_pend <= scan_issue;
      rd_idx  <= scan_cnt;
      if (scan_issue) begin
        scan_cnt <= scan_cnt + SCAN_W'(1);
      end
    end

    if (state == S_LSCAN && rd_pend && !s_f && lock_valid[rd_idx[LIDX_W-1:0]] &&
        l_rdata.addr == addr_q) begin
      s_f   <= 1'b1;
      s_idx <= rd_idx[LIDX_W-1:0];
      s_ent <= l_rdata;
    end

    if (lscan_done) begin
      scan_cnt <= '0;
      va_f     <= 1'b0;
      vb_f     <= 1'b0;
      case (cmd_q)
        CMD_ACQUIRE: res_status <= (s_f || free_any) ? STS_OK : STS_LOCK_FULL;
        CMD_UNLOCK:  res_status <= s_f ? STS_OK : STS_NOT_FOUND;
        default:     res_status <= STS_OK;
      endcase
    end

    if (state == S_VSCAN && rd_pend) begin
      if (!va_f && v_rdata == thr_q) begin
        va_f <= 1'b1;
        va   <= rd_idx[TIDX_W-1:0];
      end
      if (!vb_f && v_rdata == s_ent.owner) begin
        vb_f <= 1'b1;
        vb   <= rd_idx[TIDX_W-1:0];
      end
    end

    if (vscan_done && cmd_q == CMD_REQUEST && thr_full) begin
      res_status <= STS_THREAD_FULL;
    end

    if (state == S_ADD_A && !va_f) begin
      va   <= vcount[TIDX_W-1:0];
      va_f <= 1'b1;
    end
    if (state == S_ADD_B) begin
      if (s_ent.owner == thr_q) begin
        vb <= va;
      end else if (!vb_f) begin
        vb <= vcount[TIDX_W-1:0];
      end
    end

    // depth-first search
    if (state == S_DROOT && root < vcount) begin
      if (onstack[root[TIDX_W-1:0]] || done[root[TIDX_W-1:0]]) begin
        root <= root + TCNT_W'(1);
      end else begin
        onstack[root[TIDX_W-1:0]] <= 1'b1;
        stk_node[0] <= root[TIDX_W-1:0];
        stk_next[0] <= '0;
        sp          <= TCNT_W'(1);
      end
    end

    if (state == S_DEVAL) begin
      if (!j_f) begin
        done[top]    <= 1'b1;
        onstack[top] <= 1'b0;
        sp           <= sp_m1;
        if (sp == TCNT_W'(1)) begin
          root <= root + TCNT_W'(1);
        end
      end else begin
        stk_next[stk_idx] <= TCNT_W'(j_idx) + TCNT_W'(1);
        if (onstack[j_idx]) begin
          hit_j <= j_idx;
          p     <= '0;
        end else if (!done[j_idx] && sp < TCNT_W'(MAX_THREADS)) begin
          onstack[j_idx]               <= 1'b1;
          stk_node[sp[TIDX_W-1:0]] <= j_idx;
          stk_next[sp[TIDX_W-1:0]] <= '0;
          sp                           <= sp + TCNT_W'(1);
        end
      end
    end

    if (state == S_DFIND && top != hit_j) begin
      p <= p + TCNT_W'(1);
    end
    if (state == S_EMIT_WR && out_free && p != sp) begin
      p <= p + TCNT_W'(1);
    end

    // result beat
    if (state == S_RESULT && out_free) begin
      o_status <= res_status;
      o_dl     <= 1'b0;
      o_thr    <= '0;
      o_last   <= 1'b1;
    end
    if (state == S_EMIT_WR && out_free) begin
      o_status <= STS_OK;
      o_dl     <= 1'b1;
      o_thr    <= v_rdata;
      o_last   <= (p == sp);
    end
  end

  assign out_valid      = o_valid;
  assign status         = o_status;
  assign deadlock_found = o_dl;
  assign cycle_thread   = o_thr;
  assign last_of_run    = o_last;

endmodule

### rtl/wfgd_checker.sv
// Port-level checks of the deadlock detector's result channel, and their bind.
`timescale 1ns / 1ps
`include "wait_for_graph_deadlock_detector_defines.svh"
module wfgd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                status,
  input logic                      deadlock_found,
  input logic [wfgd_pkg::ID_W-1:0] cycle_thread,
  input logic                      last_of_run
);
  import wfgd_pkg::*;

  // a stalled beat holds
  `WFGD_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(cycle_thread) && $stable(last_of_run))
  // only cycle reports span several beats
  `WFGD_ASSERT_IMP(a_multi, out_valid && !last_of_run, deadlock_found)
  // cycle beats always carry status ok
  `WFGD_ASSERT_IMP(a_dl_ok, out_valid && deadlock_found, status == STS_OK)
  // no thread id outside a cycle report
  `WFGD_ASSERT_IMP(a_thr_zero, out_valid && !deadlock_found, cycle_thread == '0)

endmodule

bind wait_for_graph_deadlock_detector wfgd_checker u_wfgd_checker (.*);

### test/wait_for_graph_deadlock_detector_tb.sv
// Self-checking testbench for the wait-for graph deadlock detector.
`timescale 1ns / 1ps
module wait_for_graph_deadlock_detector_tb;
  import wfgd_pkg::*;

  // One lock event and one result beat, as seen on the ports.
  typedef struct {
    cmd_t        op;
    logic [63:0] thr;
    logic [63:0] addr;
  } event_t;

  typedef struct {
    status_t     st;
    logic        dl;
    logic [63:0] thr;
    logic        last;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = '0;
  logic [63:0] thread_ident = '0;
  logic [63:0] lock_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic deadlock_found;
  logic [63:0] cycle_thread;
  logic last_of_run;

  wait_for_graph_deadlock_detector dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .thread_ident(thread_ident), .lock_address(lock_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .deadlock_found(deadlock_found),
    .cycle_thread(cycle_thread), .last_of_run(last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the lock table and the wait-for graph.
  logic [63:0] g_vid [MAX_THREADS];
  int          g_vcnt;
  logic [31:0] g_adj [MAX_THREADS];
  logic        l_val [MAX_LOCKS];
  logic [63:0] l_addr [MAX_LOCKS];
  logic [63:0] l_own [MAX_LOCKS];
  int          l_wait [MAX_LOCKS];

  event_t pending_events[$];  // filled by the stimulus, drained by the driver
  beat_t  expected_beats[$];  // predicted result beats, oldest first
  int     errors = 0;
  int     send_idle_pct = 0;  // sender idle chance, percent
  int     recv_idle_pct = 0;  // receiver idle chance, percent
  int     hold_cycles = 0;    // long receiver hold-off, in cycles
  logic   busy_item = 1'b0;   // driver holds an item on the bus

  function automatic int find_vertex(logic [63:0] id);
    for (int i = 0; i < g_vcnt; i++)
      if (g_vid[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_slot(logic [63:0] a);
    for (int i = 0; i < MAX_LOCKS; i++)
      if (l_val[i] && l_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic int vertex_insert(logic [63:0] id);
    int v;
    v = find_vertex(id);
    if (v >= 0 || g_vcnt >= MAX_THREADS) return v;
    g_vid[g_vcnt] = id;
    g_vcnt++;
    return g_vcnt - 1;
  endfunction

  function automatic void push_beat(status_t st, logic dl, logic [63:0] t, logic last);
    beat_t b;
    b.st = st; b.dl = dl; b.thr = t; b.last = last;
    expected_beats.push_back(b);
  endfunction

  function automatic status_t predict_request(logic [63:0] t, logic [63:0] a);
    int s, va, vb, need;
    logic [63:0] own;
    s = find_slot(a);
    if (s < 0) return STS_OK;
    own = l_own[s];
    need = (find_vertex(t) < 0) ? 1 : 0;
    if (own != t && find_vertex(own) < 0) need++;
    if (g_vcnt + need > MAX_THREADS) return STS_THREAD_FULL;
    va = vertex_insert(t);
    vb = vertex_insert(own);
    if (va < 0 || vb < 0) return STS_THREAD_FULL;
    if (!g_adj[va][vb]) begin
      g_adj[va][vb] = 1'b1;
      if (l_wait[s] < 63) l_wait[s]++;
    end
    return STS_OK;
  endfunction

  function automatic status_t predict_acquire(logic [63:0] t, logic [63:0] a);
    int s, va, vb;
    s = find_slot(a);
    if (s < 0) begin
      for (int i = 0; i < MAX_LOCKS; i++)
        if (!l_val[i]) begin
          l_val[i] = 1'b1; l_addr[i] = a; l_own[i] = t; l_wait[i] = 0;
          return STS_OK;
        end
      return STS_LOCK_FULL;
    end
    if (l_wait[s] > 0) l_wait[s]--;
    va = find_vertex(t);
    vb = find_vertex(l_own[s]);
    if (va >= 0 && vb >= 0) g_adj[va][vb] = 1'b0;
    l_own[s] = t;
    return STS_OK;
  endfunction

  // Depth-first search with on-stack marks; first cycle in index order.
  function automatic void predict_check();
    int color [MAX_THREADS];
    int stk [MAX_THREADS];
    int nxt [MAX_THREADS];
    int sp, top, j, p;
    for (int i = 0; i < MAX_THREADS; i++) color[i] = 0;
    for (int r = 0; r < g_vcnt; r++) begin
      if (color[r] != 0) continue;
      color[r] = 1; stk[0] = r; nxt[0] = 0; sp = 1;
      while (sp > 0) begin
        top = stk[sp-1];
        j = nxt[sp-1];
        while (j < g_vcnt && !g_adj[top][j]) j++;
        if (j >= g_vcnt) begin
          color[top] = 2;
          sp--;
          continue;
        end
        nxt[sp-1] = j + 1;
        if (color[j] == 1) begin
          p = 0;
          while (p < sp && stk[p] != j) p++;
          for (; p < sp; p++) push_beat(STS_OK, 1'b1, g_vid[stk[p]], 1'b0);
          push_beat(STS_OK, 1'b1, g_vid[j], 1'b1);
          return;
        end
        if (color[j] == 0 && sp < MAX_THREADS) begin
          color[j] = 1; stk[sp] = j; nxt[sp] = 0; sp++;
        end
      end
    end
    push_beat(STS_OK, 1'b0, '0, 1'b1);
  endfunction

  function automatic void predict_event(event_t e);
    case (e.op)
      CMD_CHECK:   predict_check();
      CMD_REQUEST: push_beat(predict_request(e.thr, e.addr), 1'b0, '0, 1'b1);
      CMD_ACQUIRE: push_beat(predict_acquire(e.thr, e.addr), 1'b0, '0, 1'b1);
      default: begin
        int s;
        s = find_slot(e.addr);
        if (s < 0) push_beat(STS_NOT_FOUND, 1'b0, '0, 1'b1);
        else begin
          if (l_wait[s] == 0) l_val[s] = 1'b0;
          push_beat(STS_OK, 1'b0, '0, 1'b1);
        end
      end
    endcase
  endfunction

  // Driver: one beat at a time from the pending queue; valid holds until taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        event_t e;
        e.op = cmd_t'(cmd); e.thr = thread_ident; e.addr = lock_address;
        predict_event(e);
      end
      if (!in_valid || in_ready) begin
        if (pending_events.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          event_t e;
          e = pending_events.pop_front();
          in_valid <= 1'b1;
          cmd <= e.op; thread_ident <= e.thr; lock_address <= e.addr;
          busy_item <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          busy_item <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here.
  always @(posedge clk) begin
    if (hold_cycles > 0)
      hold_cycles <= hold_cycles - 1;
  end

  // Monitor: checks each accepted result beat; also paces out_ready.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat status=%0d dl=%0b thr=%h last=%0b", $time,
                   status, deadlock_found, cycle_thread, last_of_run);
          errors++;
        end else begin
          beat_t x;
          x = expected_beats.pop_front();
          if (status !== x.st || deadlock_found !== x.dl ||
              cycle_thread !== x.thr || last_of_run !== x.last) begin
            $display("%0t: mismatch expected st=%0d dl=%0b thr=%h last=%0b", $time,
                     x.st, x.dl, x.thr, x.last);
            $display("%0t:          actual   st=%0d dl=%0b thr=%h last=%0b", $time,
                     status, deadlock_found, cycle_thread, last_of_run);
            errors++;
          end
        end
      end
      if (hold_cycles > 0)
        out_ready <= 1'b0;
      else
        out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Stimulus helpers.
  function automatic void queue_event(cmd_t op, logic [63:0] t, logic [63:0] a);
    event_t e;
    e.op = op; e.thr = t; e.addr = a;
    pending_events.push_back(e);
  endfunction

  task automatic drain();
    while (pending_events.size() > 0 || busy_item || expected_beats.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Small id pools so requests hit held locks and cycles form.
  function automatic logic [63:0] pick_thread(int pool);
    return 64'h1000 + $urandom_range(pool - 1, 0);
  endfunction

  function automatic logic [63:0] pick_lock(int pool);
    return 64'hA000 + $urandom_range(pool - 1, 0);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    g_vcnt = 0;
    for (int i = 0; i < MAX_THREADS; i++) g_adj[i] = '0;
    for (int i = 0; i < MAX_LOCKS; i++) begin
      l_val[i] = 1'b0; l_wait[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme ids, every op, self edge, two-thread cycle,
    // unknown unlock, unlock with waiters, repeated request, empty check.
    queue_event(CMD_CHECK, rand64(), rand64());
    queue_event(CMD_REQUEST, '1, '1);                // free lock
    queue_event(CMD_UNLOCK, '0, 64'h55);             // not found
    queue_event(CMD_ACQUIRE, '1, '1);
    queue_event(CMD_ACQUIRE, '0, '0);
    queue_event(CMD_REQUEST, '0, '1);                // 0 waits for all ones
    queue_event(CMD_REQUEST, '0, '1);                // repeat, no new edge
    queue_event(CMD_CHECK, '0, '0);
    queue_event(CMD_REQUEST, '1, '0);                // cycle of two
    queue_event(CMD_CHECK, '0, '0);
    queue_event(CMD_UNLOCK, '0, '1);                 // waiters, stays valid
    queue_event(CMD_ACQUIRE, '0, '1);                // takeover drops edge
    queue_event(CMD_CHECK, '0, '0);
    queue_event(CMD_REQUEST, '0, '0);                // self edge on own lock
    queue_event(CMD_CHECK, '0, '0);
    queue_event(CMD_UNLOCK, '0, '0);
    queue_event(CMD_ACQUIRE, 64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555);
    queue_event(CMD_UNLOCK, 64'h1, 64'hAAAA_5555_AAAA_5555);
    drain();

    // Fill the lock table past its end for a lock-table-full status.
    for (int i = 0; i < MAX_LOCKS + 2; i++)
      queue_event(CMD_ACQUIRE, 64'h7700 + i, 64'hF000 + i);
    // Many distinct waiters run the thread table out.
    for (int i = 0; i < MAX_THREADS + 4; i++)
      queue_event(CMD_REQUEST, 64'hC000 + i, 64'hF000 + (i % MAX_LOCKS));
    queue_event(CMD_CHECK, '0, '0);
    // Receiver holds off long while the sender keeps offering.
    hold_cycles = 3000;
    drain();

    // Random phases with the three idling profiles.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 64 : 0;
      recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 16 : 0;
      for (int n = 0; n < 97; n++) begin
        int r;
        cmd_t op;
        r = $urandom_range(99, 0);
        op = (r < 35) ? CMD_REQUEST : (r < 65) ? CMD_ACQUIRE :
             (r < 85) ? CMD_UNLOCK : CMD_CHECK;
        if ($urandom_range(9, 0) == 0)
          queue_event(op, rand64(), rand64());
        else
          queue_event(op, pick_thread(6), pick_lock(5));
      end
      // Sender pauses until every expected beat has come.
      drain();
    end

    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/wfgd_pkg.sv
rtl/wfgd_ram.sv
rtl/wait_for_graph_deadlock_detector.sv
rtl/wfgd_checker.sv
test/wait_for_graph_deadlock_detector_tb.sv
